// File: src/tle_pkg.sv
// types and constants shared by the tour length evaluator
package tle_pkg;

	localparam int CITY_W  = 7;
	localparam int COORD_W = 10;
	localparam int LEN_W   = 18;
	localparam int RAD_W   = 21;
	localparam int ROOT_W  = 11;

	localparam logic [LEN_W-1:0] SUM_MAX = {LEN_W{1'b1}};

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_TOUR = 1'b1
	} op_t;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_FETCH = 7'b0000010,
		S_SQX   = 7'b0000100,
		S_SQY   = 7'b0001000,
		S_ROOT  = 7'b0010000,
		S_ACC   = 7'b0100000,
		S_DONE  = 7'b1000000
	} state_t;

endpackage

// File: src/tour_length_evaluator_top.sv
// closed-tour length evaluator: point table, shared square and bit-serial square root
// a load item with an in-range city writes the point table; a tour item that is not last runs a table read,
// two squares on one multiplier, 11 root steps, sum; a tour's first item only reads
// a last tour item runs its own edge, then the closing edge, then shows the tour's result;
// a one-city tour runs none; a result held by the receiver keeps the next one waiting
// reset clears the sequencer, tour state and sum; the point table is not cleared
module tour_length_evaluator_top #(
	parameter int MAX_CITIES = 128
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  logic                          operation,
	input  logic [tle_pkg::CITY_W-1:0]    city,
	input  logic [tle_pkg::COORD_W-1:0]   x_coord,
	input  logic [tle_pkg::COORD_W-1:0]   y_coord,
	input  logic                          last,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [tle_pkg::LEN_W-1:0]     tour_length
);
	import tle_pkg::*;

	localparam int AW = $clog2(MAX_CITIES);

	state_t state_q;

	logic [2*COORD_W-1:0] mem [MAX_CITIES];
	logic [2*COORD_W-1:0] rd_q;
	logic                 in_range_q;
	logic                 last_q;
	logic                 closed_q;
	logic                 in_tour_q;

	logic [COORD_W-1:0] first_x_q, first_y_q, prev_x_q, prev_y_q;
	logic [COORD_W-1:0] ax_q, ay_q, bx_q, by_q;
	logic [LEN_W-1:0]   sum_q;
	logic [RAD_W-1:0]   sq_q, v_q, root_q, bit_q;
	logic               out_valid_q;
	logic [LEN_W-1:0]   out_len_q;

	logic               item_acc, load_acc, tour_acc, in_range;
	logic [AW+CITY_W-1:0] city_ext;
	logic [AW-1:0]      addr;
	logic [COORD_W-1:0] cur_x, cur_y, dx, dy, mul_op;
	logic [2*COORD_W-1:0] mul_res;
	logic [RAD_W:0]     trial;
	logic [LEN_W:0]     sum_add;
	logic               out_free;

	assign item_stall   = (state_q != S_IDLE);
	assign item_acc     = item_valid && !item_stall;
	assign load_acc     = item_acc && (operation == OP_LOAD);
	assign tour_acc     = item_acc && (operation == OP_TOUR);
	assign city_ext     = {{AW{1'b0}}, city};
	assign addr         = city_ext[AW-1:0];
	assign in_range     = (32'(city) < MAX_CITIES);

	assign cur_x = in_range_q ? rd_q[2*COORD_W-1:COORD_W] : '0;
	assign cur_y = in_range_q ? rd_q[COORD_W-1:0] : '0;

	assign dx      = (ax_q > bx_q) ? (ax_q - bx_q) : (bx_q - ax_q);
	assign dy      = (ay_q > by_q) ? (ay_q - by_q) : (by_q - ay_q);
	// one multiplier squares dx, then dy in the following cycle
	assign mul_op  = (state_q == S_SQX) ? dx : dy;
	assign mul_res = mul_op * mul_op;

	assign trial   = {1'b0, root_q} + {1'b0, bit_q};
	assign sum_add = {1'b0, sum_q} + (LEN_W+1)'(root_q[ROOT_W-1:0]);
	assign out_free = !out_valid_q || !result_stall;

	assign result_valid = out_valid_q;
	assign tour_length  = out_len_q;

	always_ff @(posedge clk) begin
		if (load_acc && in_range) begin
			mem[addr] <= {x_coord, y_coord};
		end
		if (tour_acc) begin
			rd_q <= mem[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			in_range_q  <= 1'b0;
			last_q      <= 1'b0;
			closed_q    <= 1'b0;
			in_tour_q   <= 1'b0;
			first_x_q   <= '0;
			first_y_q   <= '0;
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			sum_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// the result stage reloads the output register itself
			if (out_valid_q && !result_stall && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (tour_acc) begin
						in_range_q <= in_range;
						last_q     <= last;
						closed_q   <= 1'b0;
						state_q    <= S_FETCH;
					end
				end
				S_FETCH: begin
					prev_x_q <= cur_x;
					prev_y_q <= cur_y;
					if (!in_tour_q) begin
						// first city of a tour adds no edge
						first_x_q <= cur_x;
						first_y_q <= cur_y;
						sum_q     <= '0;
						in_tour_q <= 1'b1;
						state_q   <= last_q ? S_DONE : S_IDLE;
					end else begin
						ax_q    <= prev_x_q;
						ay_q    <= prev_y_q;
						bx_q    <= cur_x;
						by_q    <= cur_y;
						state_q <= S_SQX;
					end
				end
				S_SQX: begin
					sq_q    <= RAD_W'(mul_res);
					state_q <= S_SQY;
				end
				S_SQY: begin
					v_q     <= sq_q + RAD_W'(mul_res);
					root_q  <= '0;
					bit_q   <= RAD_W'(1) << (RAD_W - 1);
					state_q <= S_ROOT;
				end
				S_ROOT: begin
					if ({1'b0, v_q} >= trial) begin
						v_q    <= v_q - trial[RAD_W-1:0];
						root_q <= (root_q >> 1) + bit_q;
					end else begin
						root_q <= root_q >> 1;
					end
					bit_q <= bit_q >> 2;
					if (bit_q[0]) begin
						state_q <= S_ACC;
					end
				end
				S_ACC: begin
					sum_q <= (sum_add > {1'b0, SUM_MAX}) ? SUM_MAX : sum_add[LEN_W-1:0];
					if (last_q && !closed_q) begin
						// closing edge back to the first city
						ax_q     <= prev_x_q;
						ay_q     <= prev_y_q;
						bx_q     <= first_x_q;
						by_q     <= first_y_q;
						closed_q <= 1'b1;
						state_q  <= S_SQX;
					end else begin
						state_q <= last_q ? S_DONE : S_IDLE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_len_q   <= sum_q;
						out_valid_q <= 1'b1;
						sum_q       <= '0;
						in_tour_q   <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_root_bit_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ROOT) |-> $onehot(bit_q))
		else $error("root step bit is not a single bit");

	a_root_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ACC) |-> (root_q[RAD_W-1:ROOT_W] == '0))
		else $error("edge length wider than root width");

	a_done_needs_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE) |-> (last_q && in_tour_q))
		else $error("result stage reached without a last item in a tour");

	a_tour_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		tour_acc |=> (state_q == S_FETCH))
		else $error("tour item not followed by table read");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == S_DONE))
		else $error("result appeared outside result stage");

endmodule
